FILE: rtl/trial_division_prime_test_assert.svh
// ----------------------------------------------------------------------------
// Trial division prime test assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDPT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TDPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared width default, sequencer states and divider control and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tdpt_pkg;

  localparam int unsigned DefWidth = 32;

  typedef enum logic [2:0] {
    StIdle,
    StClassify,
    StCheck,
    StDiv,
    StFinish
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic rem_zero;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tdpt_rem_unit.sv
// ----------------------------------------------------------------------------
// Trial division prime test remainder unit
// Restoring divider that settles one quotient bit per cycle while running, keeps
// only the remainder and reports whether the final remainder is zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tdpt_rem_unit #(
  parameter int unsigned WIDTH = tdpt_pkg::DefWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tdpt_pkg::div_ctrl_t ctrl_i,
  input  wire logic [WIDTH-1:0]    dividend_i,
  input  wire logic [WIDTH-1:0]    divisor_i,
  output tdpt_pkg::div_stat_t      stat_o
);

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] LastCnt = CntW'(WIDTH - 1);

  logic            running_q, running_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;

  assign trial = {rem_q, dvd_q[WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    if (ctrl_i.start) begin
      running_d = 1'b1;
      cnt_d     = '0;
      dvd_d     = dividend_i;
      dvs_d     = divisor_i;
      rem_d     = '0;
    end else if (running_q) begin
      dvd_d = {dvd_q[WIDTH-2:0], 1'b0};
      if (!diff[WIDTH]) begin
        rem_d = diff[WIDTH-1:0];
      end else begin
        rem_d = trial[WIDTH-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.busy     = running_q;
  assign stat_o.done     = done_q;
  assign stat_o.rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

FILE: rtl/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// Trial division prime test
// Tests one candidate at a time, checking the low bit for evenness and dividing
// by odd divisors up to the square root with one shared restoring remainder unit.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o   candidate_i
//   out      output     out_valid_o / out_stall_i candidate_echo_o, is_prime_o
//
// Candidates below four and even ones go from classification straight to finish.
// Each odd divisor tried takes a check state and a full remainder unit run,
// so a prime near 2**WIDTH tries about 2**(WIDTH/2 - 1) odd divisors.
// Input is stalled from acceptance until the result enters the output register.
// A result waits in the sequencer while the output register is held by a stall.
// Reset is asynchronous and active low and leaves the block idle and empty.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test #(
  parameter int unsigned WIDTH = tdpt_pkg::DefWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] candidate_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WIDTH-1:0]      candidate_echo_o,
  output logic                  is_prime_o
);

  tdpt_pkg::state_e    state_q, state_d;
  tdpt_pkg::div_ctrl_t div_ctrl;
  tdpt_pkg::div_stat_t div_stat;

  logic [WIDTH-1:0] cand_q, cand_d;
  logic [WIDTH-1:0] div_q, div_d;
  logic [WIDTH:0]   sq_q, sq_d;
  logic             prime_q, prime_d;
  logic             out_valid_q;
  logic [WIDTH-1:0] echo_q;
  logic             res_q;
  logic             in_accept;
  logic             out_load;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_load  = (state_q == tdpt_pkg::StFinish) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tdpt_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = tdpt_pkg::StClassify;
        end
      end
      tdpt_pkg::StClassify: begin
        if ((cand_q[WIDTH-1:2] == '0) || !cand_q[0]) begin
          state_d = tdpt_pkg::StFinish;
        end else begin
          state_d = tdpt_pkg::StCheck;
        end
      end
      tdpt_pkg::StCheck: begin
        if (sq_q > {1'b0, cand_q}) begin
          state_d = tdpt_pkg::StFinish;
        end else begin
          state_d = tdpt_pkg::StDiv;
        end
      end
      tdpt_pkg::StDiv: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            state_d = tdpt_pkg::StFinish;
          end else begin
            state_d = tdpt_pkg::StCheck;
          end
        end
      end
      tdpt_pkg::StFinish: begin
        if (out_load) begin
          state_d = tdpt_pkg::StIdle;
        end
      end
      default: state_d = tdpt_pkg::StIdle;
    endcase
  end

  always_comb begin
    cand_d         = cand_q;
    div_d          = div_q;
    sq_d           = sq_q;
    prime_d        = prime_q;
    div_ctrl.start = 1'b0;
    in_stall_o     = 1'b1;
    unique case (state_q)
      tdpt_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_accept) begin
          cand_d = candidate_i;
        end
      end
      tdpt_pkg::StClassify: begin
        div_d = WIDTH'(3);
        sq_d  = (WIDTH + 1)'(9);
        if (cand_q[WIDTH-1:1] == '0) begin
          prime_d = 1'b0;
        end else if (cand_q[WIDTH-1:2] == '0) begin
          prime_d = 1'b1;
        end else begin
          prime_d = cand_q[0];
        end
      end
      tdpt_pkg::StCheck: begin
        if (sq_q > {1'b0, cand_q}) begin
          prime_d = 1'b1;
        end else begin
          div_ctrl.start = 1'b1;
        end
      end
      tdpt_pkg::StDiv: begin
        if (div_stat.done) begin
          if (div_stat.rem_zero) begin
            prime_d = 1'b0;
          end else begin
            div_d = div_q + WIDTH'(2);
            sq_d  = sq_q + {div_q[WIDTH-2:0], 2'b00} + (WIDTH + 1)'(4);
          end
        end
      end
      tdpt_pkg::StFinish: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q  <= cand_d;
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    if (out_load) begin
      echo_q <= cand_q;
      res_q  <= prime_q;
    end
  end

  tdpt_rem_unit #(
    .WIDTH(WIDTH)
  ) u_rem_unit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .dividend_i(cand_q),
    .divisor_i (div_q),
    .stat_o    (div_stat)
  );

  assign out_valid_o      = out_valid_q;
  assign candidate_echo_o = echo_q;
  assign is_prime_o       = res_q;

`include "trial_division_prime_test_assert.svh"

  `TDPT_ASSERT_NEXT(a_accept_classify, in_accept, state_q == tdpt_pkg::StClassify)
  `TDPT_ASSERT_NEXT(a_start_runs, div_ctrl.start, div_stat.busy)
  `TDPT_ASSERT_SAME(a_div_active, state_q == tdpt_pkg::StDiv, div_stat.busy || div_stat.done)
  `TDPT_ASSERT_SAME(a_even_composite,
    out_valid_o && !candidate_echo_o[0] && (candidate_echo_o[WIDTH-1:2] != '0), !is_prime_o)

endmodule

`default_nettype wire
